[design/perlin_gradient_noise_2d_macros.svh]
// ----------------------------------------------------------------------------
// perlin_gradient_noise_2d assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef PERLIN_GRADIENT_NOISE_2D_MACROS_SVH
`define PERLIN_GRADIENT_NOISE_2D_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PGN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PGN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/pgn_pkg.sv]
// ----------------------------------------------------------------------------
// pgn_pkg
// Widths, word types and arithmetic helpers for the 2D gradient noise block.
// ----------------------------------------------------------------------------
`default_nettype none

package pgn_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int TABLE_SIZE = 256;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int PERM_W     = 8;
	localparam int GRAD_W     = 3;
	localparam int OUT_W      = 18;
	localparam int OUT_FRAC   = 16;
	localparam int QUO_W      = IDX_W + FRAC_BITS;
	localparam int DIV_STEPS  = COORD_BITS + FRAC_BITS;
	localparam int UF_W       = FRAC_BITS + 1;
	localparam int SF_W       = FRAC_BITS + 2;
	localparam int DOT_W      = FRAC_BITS + 3;
	localparam int FADE_W     = FRAC_BITS + 6;
	localparam int LERP_W     = DOT_W + 1;
	localparam int RND_W      = 64;
	localparam int OUT_SHR    = (FRAC_BITS + 1 >= OUT_FRAC) ? FRAC_BITS + 1 - OUT_FRAC : 0;
	localparam int OUT_SHL    = (FRAC_BITS + 1 >= OUT_FRAC) ? 0 : OUT_FRAC - 1 - FRAC_BITS;

	localparam logic signed [RND_W-1:0] OUT_MAX = (RND_W'(1) <<< (OUT_W - 1)) - RND_W'(1);
	localparam logic signed [RND_W-1:0] OUT_MIN = -(RND_W'(1) <<< (OUT_W - 1));

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [COORD_BITS-1:0] x_coord;
		logic [COORD_BITS-1:0] y_coord;
		logic [COORD_BITS-1:0] cell_scale;
		logic [IDX_W-1:0]      table_index;
		logic [PERM_W-1:0]     table_value;
	} in_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] noise_value;
		logic                    scale_error;
	} out_word_t;

	typedef struct packed {
		logic                 valid;
		op_t                  op;
		logic                 err;
		logic [IDX_W-1:0]     cx;
		logic [IDX_W-1:0]     cy;
		logic [IDX_W-1:0]     scale;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
		logic [IDX_W-1:0]     tidx;
		logic [PERM_W-1:0]    tval;
	} div_out_t;

	// shift right by k, round to nearest, ties away from zero
	function automatic logic signed [RND_W-1:0] round_q(input logic signed [RND_W-1:0] v,
		input int k);
		logic signed [RND_W-1:0] half;
		logic [RND_W-1:0]        sum;
		if (k == 0) return v;
		half = RND_W'(1) <<< (k - 1);
		sum  = v + half - {{(RND_W-1){1'b0}}, v[RND_W-1]};
		return $signed(sum) >>> k;
	endfunction

	function automatic logic signed [DOT_W-1:0] dot_q(input logic [GRAD_W-1:0] g,
		input logic signed [SF_W-1:0] dx, input logic signed [SF_W-1:0] dy);
		logic signed [DOT_W-1:0] ex;
		logic signed [DOT_W-1:0] ey;
		logic signed [DOT_W-1:0] r;
		ex = DOT_W'(dx);
		ey = DOT_W'(dy);
		unique case (g)
			3'd0: r = ex + ey;
			3'd1: r = ey - ex;
			3'd2: r = ex - ey;
			3'd3: r = -ex - ey;
			3'd4: r = ex;
			3'd5: r = -ex;
			3'd6: r = ey;
			default: r = -ey;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[design/pgn_in_if.sv]
// ----------------------------------------------------------------------------
// pgn_in_if
// Request channel: load or evaluate word with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pgn_in_if;
	import pgn_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/pgn_out_if.sv]
// ----------------------------------------------------------------------------
// pgn_out_if
// Result channel: noise word with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface pgn_out_if;
	import pgn_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/perlin_gradient_noise_2d.sv]
// ----------------------------------------------------------------------------
// perlin_gradient_noise_2d
// 2D gradient noise: divide, hash through the permutation memory, fade,
// bilinear blend, output (1+n)/2 in signed Q.16.
//
//   channel  dir  handshake          word
//   req      in   req.valid/ready    op, x/y coord, scale, table index/value
//   rsp      out  rsp.valid/ready    noise_value, scale_error
//
// One word per cycle while req.ready is high. An evaluate passes 32
// divider stages (one quotient bit each), two permutation reads, five blend
// stages and the output register. Loads write the table when they reach
// the first read stage, so table accesses stay in word order. A load gives
// no result. req.ready drops only while the skid register holds a word; the
// whole pipeline then holds. Reset clears all but fade and RAM registers.
// ----------------------------------------------------------------------------
`default_nettype none

module perlin_gradient_noise_2d (
	input  logic     clk,
	input  logic     arst_n,
	pgn_in_if.sink   req,
	pgn_out_if.source rsp
);
	import pgn_pkg::*;

	localparam logic signed [SF_W-1:0]  ONE_SF = SF_W'(1) <<< FRAC_BITS;
	localparam logic signed [RND_W-1:0] ONE_W  = RND_W'(1) <<< FRAC_BITS;

	typedef struct packed {
		logic                 valid;
		logic                 err;
		logic [IDX_W-1:0]     cx;
		logic [IDX_W-1:0]     scale;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
	} ev1_t;

	typedef struct packed {
		logic                 valid;
		logic                 err;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
	} ev2_t;

	typedef struct packed {
		logic                    valid;
		logic                    err;
		logic signed [DOT_W-1:0] s;
		logic signed [DOT_W-1:0] t;
		logic signed [DOT_W-1:0] u;
		logic signed [DOT_W-1:0] v;
	} ev3_t;

	typedef struct packed {
		logic                          valid;
		logic                          err;
		logic signed [DOT_W-1:0]       s;
		logic signed [DOT_W-1:0]       v;
		logic signed [SF_W+LERP_W-1:0] ma;
		logic signed [SF_W+LERP_W-1:0] mb;
		logic [UF_W-1:0]               uy;
	} ev4_t;

	typedef struct packed {
		logic                     valid;
		logic                     err;
		logic signed [LERP_W-1:0] ist;
		logic signed [LERP_W-1:0] iuv;
		logic [UF_W-1:0]          uy;
	} ev5_t;

	typedef struct packed {
		logic                        valid;
		logic                        err;
		logic signed [LERP_W-1:0]    ist;
		logic signed [SF_W+LERP_W:0] mc;
	} ev6_t;

	typedef struct packed {
		logic                   valid;
		logic                   err;
		logic signed [LERP_W:0] n;
	} ev7_t;

	logic      adv;
	div_out_t  d;
	logic      perm_we;
	logic [IDX_W-1:0]  cy_nx;
	logic [PERM_W-1:0] row_a;
	logic [PERM_W-1:0] row_b;
	logic [IDX_W-1:0]  h0, h1, h2, h3;
	logic [PERM_W-1:0] pg0, pg1, pg2, pg3;
	logic [UF_W-1:0]   ux, uy;

	ev1_t ev_s1;
	ev2_t ev_s2;
	ev3_t ev_s3;
	ev4_t ev_s4;
	ev5_t ev_s5;
	ev6_t ev_s6;
	ev7_t ev_s7;

	ev3_t ev3_n;
	ev4_t ev4_n;
	ev5_t ev5_n;
	ev6_t ev6_n;
	ev7_t ev7_n;

	logic signed [SF_W-1:0]     dx0, dx1, dy0, dy1;
	logic signed [LERP_W-1:0]   d_ts, d_uv;
	logic signed [LERP_W:0]     d_n;
	logic signed [RND_W-1:0]    val, val_r;
	out_word_t res;

	logic      o_valid_q;
	out_word_t o_word_q;
	logic      k_valid_q;
	out_word_t k_word_q;

	assign adv       = !k_valid_q;
	assign req.ready = adv;

	pgn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (req.valid),
		.in_word  (req.data),
		.out      (d)
	);

	assign perm_we = adv && d.valid && (d.op == OP_LOAD);
	assign cy_nx   = d.cy + IDX_W'(1);

	pgn_ram #(.DEPTH(TABLE_SIZE), .WIDTH(PERM_W)) u_perm_row (
		.clk(clk), .en(adv), .we(perm_we), .waddr(d.tidx), .wdata(d.tval),
		.raddr_a(d.cy), .raddr_b(cy_nx), .rdata_a(row_a), .rdata_b(row_b)
	);

	pgn_fade u_fade_x (.clk(clk), .en(adv), .f(d.fx), .fade(ux));
	pgn_fade u_fade_y (.clk(clk), .en(adv), .f(d.fy), .fade(uy));

	// corner hashes
	assign h0 = ev_s1.cx + row_a + ev_s1.scale;
	assign h1 = ev_s1.cx + IDX_W'(1) + row_a + ev_s1.scale;
	assign h2 = ev_s1.cx + IDX_W'(1) + row_b + ev_s1.scale;
	assign h3 = ev_s1.cx + row_b + ev_s1.scale;

	pgn_ram #(.DEPTH(TABLE_SIZE), .WIDTH(PERM_W)) u_perm_lo (
		.clk(clk), .en(adv), .we(perm_we), .waddr(d.tidx), .wdata(d.tval),
		.raddr_a(h0), .raddr_b(h1), .rdata_a(pg0), .rdata_b(pg1)
	);

	pgn_ram #(.DEPTH(TABLE_SIZE), .WIDTH(PERM_W)) u_perm_hi (
		.clk(clk), .en(adv), .we(perm_we), .waddr(d.tidx), .wdata(d.tval),
		.raddr_a(h2), .raddr_b(h3), .rdata_a(pg2), .rdata_b(pg3)
	);

	always_comb begin
		dx0 = $signed({2'b00, ev_s2.fx});
		dy0 = $signed({2'b00, ev_s2.fy});
		dx1 = dx0 - ONE_SF;
		dy1 = dy0 - ONE_SF;
		ev3_n.valid = ev_s2.valid;
		ev3_n.err   = ev_s2.err;
		ev3_n.s     = dot_q(pg0[GRAD_W-1:0], dx0, dy0);
		ev3_n.t     = dot_q(pg1[GRAD_W-1:0], dx1, dy0);
		ev3_n.u     = dot_q(pg2[GRAD_W-1:0], dx1, dy1);
		ev3_n.v     = dot_q(pg3[GRAD_W-1:0], dx0, dy1);
	end

	always_comb begin
		d_ts = LERP_W'(ev_s3.t) - LERP_W'(ev_s3.s);
		d_uv = LERP_W'(ev_s3.u) - LERP_W'(ev_s3.v);
		ev4_n.valid = ev_s3.valid;
		ev4_n.err   = ev_s3.err;
		ev4_n.s     = ev_s3.s;
		ev4_n.v     = ev_s3.v;
		ev4_n.ma    = $signed({1'b0, ux}) * d_ts;
		ev4_n.mb    = $signed({1'b0, ux}) * d_uv;
		ev4_n.uy    = uy;
	end

	always_comb begin
		ev5_n.valid = ev_s4.valid;
		ev5_n.err   = ev_s4.err;
		ev5_n.ist   = LERP_W'(RND_W'(ev_s4.s) + round_q(RND_W'(ev_s4.ma), FRAC_BITS));
		ev5_n.iuv   = LERP_W'(RND_W'(ev_s4.v) + round_q(RND_W'(ev_s4.mb), FRAC_BITS));
		ev5_n.uy    = ev_s4.uy;
	end

	always_comb begin
		d_n = (LERP_W + 1)'(ev_s5.iuv) - (LERP_W + 1)'(ev_s5.ist);
		ev6_n.valid = ev_s5.valid;
		ev6_n.err   = ev_s5.err;
		ev6_n.ist   = ev_s5.ist;
		ev6_n.mc    = $signed({1'b0, ev_s5.uy}) * d_n;
	end

	always_comb begin
		ev7_n.valid = ev_s6.valid;
		ev7_n.err   = ev_s6.err;
		ev7_n.n     = (LERP_W + 1)'(RND_W'(ev_s6.ist) + round_q(RND_W'(ev_s6.mc), FRAC_BITS));
	end

	// rescale 1+n to the output format and saturate
	always_comb begin
		val   = RND_W'(ev_s7.n) + ONE_W;
		val_r = round_q(val, OUT_SHR) <<< OUT_SHL;
		if (val_r > OUT_MAX) begin
			val_r = OUT_MAX;
		end else if (val_r < OUT_MIN) begin
			val_r = OUT_MIN;
		end
		res.scale_error = ev_s7.err;
		res.noise_value = ev_s7.err ? '0 : OUT_W'(val_r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s1 <= '0;
			ev_s2 <= '0;
			ev_s3 <= '0;
			ev_s4 <= '0;
			ev_s5 <= '0;
			ev_s6 <= '0;
			ev_s7 <= '0;
		end else if (adv) begin
			ev_s1.valid <= d.valid && (d.op == OP_EVAL);
			ev_s1.err   <= d.err;
			ev_s1.cx    <= d.cx;
			ev_s1.scale <= d.scale;
			ev_s1.fx    <= d.fx;
			ev_s1.fy    <= d.fy;
			ev_s2.valid <= ev_s1.valid;
			ev_s2.err   <= ev_s1.err;
			ev_s2.fx    <= ev_s1.fx;
			ev_s2.fy    <= ev_s1.fy;
			ev_s3       <= ev3_n;
			ev_s4       <= ev4_n;
			ev_s5       <= ev5_n;
			ev_s6       <= ev6_n;
			ev_s7       <= ev7_n;
		end
	end

	// output register plus skid word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
			o_word_q  <= '0;
			k_valid_q <= 1'b0;
			k_word_q  <= '0;
		end else if (o_valid_q && !rsp.ready) begin
			if (adv && ev_s7.valid) begin
				k_valid_q <= 1'b1;
				k_word_q  <= res;
			end
		end else if (k_valid_q) begin
			o_valid_q <= 1'b1;
			o_word_q  <= k_word_q;
			k_valid_q <= 1'b0;
		end else begin
			o_valid_q <= ev_s7.valid;
			o_word_q  <= res;
		end
	end

	assign rsp.valid = o_valid_q;
	assign rsp.data  = o_word_q;

endmodule

`default_nettype wire

[design/pgn_ram.sv]
// ----------------------------------------------------------------------------
// pgn_ram
// One write port, two registered read ports, read-before-write.
// ----------------------------------------------------------------------------
`default_nettype none

module pgn_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (en) begin
			rd_a_q <= mem_q[raddr_a];
			rd_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

`default_nettype wire

[design/pgn_div.sv]
// ----------------------------------------------------------------------------
// pgn_div
// Pipelined restoring divider: (coord << FRAC_BITS) / scale for x and y,
// one quotient bit per stage. Upper quotient bits give the cell, lower the
// fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module pgn_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  pgn_pkg::in_word_t in_word,
	output pgn_pkg::div_out_t out
);
	import pgn_pkg::*;

	typedef struct packed {
		logic                  valid;
		op_t                   op;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] sc;
		logic [IDX_W-1:0]      tidx;
		logic [PERM_W-1:0]     tval;
		logic [COORD_BITS-1:0] xr;
		logic [COORD_BITS-1:0] yr;
		logic [QUO_W-1:0]      xq;
		logic [QUO_W-1:0]      yq;
	} div_st_t;

	function automatic div_st_t div_step(input div_st_t a, input logic xb, input logic yb);
		div_st_t               r;
		logic [COORD_BITS:0]   tx;
		logic [COORD_BITS:0]   ty;
		logic [COORD_BITS:0]   dv;
		logic                  gx;
		logic                  gy;
		r  = a;
		dv = {1'b0, a.sc};
		tx = {a.xr, xb};
		ty = {a.yr, yb};
		gx = (tx >= dv);
		gy = (ty >= dv);
		r.xr = gx ? COORD_BITS'(tx - dv) : tx[COORD_BITS-1:0];
		r.yr = gy ? COORD_BITS'(ty - dv) : ty[COORD_BITS-1:0];
		r.xq = {a.xq[QUO_W-2:0], gx};
		r.yq = {a.yq[QUO_W-2:0], gy};
		return r;
	endfunction

	div_st_t st_in;
	div_st_t st_q [DIV_STEPS];
	div_st_t last;

	always_comb begin
		st_in       = '0;
		st_in.valid = in_valid;
		st_in.op    = in_word.op;
		st_in.x     = in_word.x_coord;
		st_in.y     = in_word.y_coord;
		st_in.sc    = in_word.cell_scale;
		st_in.tidx  = in_word.table_index;
		st_in.tval  = in_word.table_value;
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		div_st_t prev;
		logic    xb;
		logic    yb;

		if (k == 0) begin : g_first
			assign prev = st_in;
		end else begin : g_next
			assign prev = st_q[k-1];
		end

		if (k < COORD_BITS) begin : g_bit
			assign xb = prev.x[COORD_BITS-1-k];
			assign yb = prev.y[COORD_BITS-1-k];
		end else begin : g_zero
			assign xb = 1'b0;
			assign yb = 1'b0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st_q[k] <= '0;
			end else if (en) begin
				st_q[k] <= div_step(prev, xb, yb);
			end
		end
	end

	assign last = st_q[DIV_STEPS-1];

	always_comb begin
		out.valid = last.valid;
		out.op    = last.op;
		out.err   = (last.sc == '0);
		out.cx    = last.xq[QUO_W-1:FRAC_BITS];
		out.cy    = last.yq[QUO_W-1:FRAC_BITS];
		out.scale = last.sc[IDX_W-1:0];
		out.fx    = last.xq[FRAC_BITS-1:0];
		out.fy    = last.yq[FRAC_BITS-1:0];
		out.tidx  = last.tidx;
		out.tval  = last.tval;
	end

endmodule

`default_nettype wire

[design/pgn_fade.sv]
// ----------------------------------------------------------------------------
// pgn_fade
// Three-stage quintic fade 6t^5-15t^4+10t^3 in fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

module pgn_fade (
	input  logic                          clk,
	input  logic                          en,
	input  logic [pgn_pkg::FRAC_BITS-1:0] f,
	output logic [pgn_pkg::UF_W-1:0]      fade
);
	import pgn_pkg::*;

	localparam logic [FADE_W-1:0]        C15 = FADE_W'(15) << FRAC_BITS;
	localparam logic signed [RND_W-1:0]  C10 = RND_W'(10) <<< FRAC_BITS;

	logic signed [FADE_W-1:0]          a_n;
	logic [2*FRAC_BITS-1:0]            sq;
	logic signed [FADE_W-1:0]          a_s1;
	logic [UF_W-1:0]                   f2_s1;
	logic [FRAC_BITS-1:0]              f_s1;

	logic signed [FADE_W+FRAC_BITS:0]  pa;
	logic [UF_W+FRAC_BITS-1:0]         pt;
	logic signed [FADE_W-1:0]          b_s2;
	logic [UF_W-1:0]                   t3_s2;

	logic signed [FADE_W+UF_W:0]       pc;
	logic [UF_W-1:0]                   fade_s3;

	assign a_n = $signed(FADE_W'(FADE_W'(f) * FADE_W'(6)) - C15);
	assign sq  = {{FRAC_BITS{1'b0}}, f} * {{FRAC_BITS{1'b0}}, f};

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= a_n;
			f2_s1 <= UF_W'(round_q(RND_W'(sq), FRAC_BITS));
			f_s1  <= f;
		end
	end

	assign pa = a_s1 * $signed({1'b0, f_s1});
	assign pt = f2_s1 * f_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			b_s2  <= FADE_W'(round_q(RND_W'(pa), FRAC_BITS) + C10);
			t3_s2 <= UF_W'(round_q(RND_W'(pt), FRAC_BITS));
		end
	end

	assign pc = b_s2 * $signed({1'b0, t3_s2});

	always_ff @(posedge clk) begin
		if (en) begin
			fade_s3 <= UF_W'(round_q(RND_W'(pc), FRAC_BITS));
		end
	end

	assign fade = fade_s3;

endmodule

`default_nettype wire

[design/pgn_chk.sv]
// ----------------------------------------------------------------------------
// pgn_chk
// Port-level checks for perlin_gradient_noise_2d, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "perlin_gradient_noise_2d_macros.svh"

module pgn_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input pgn_pkg::out_word_t rsp_data
);
	import pgn_pkg::*;

	`PGN_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result word changed while stalled")
	`PGN_ASSERT_NOW(a_err_zero, rsp_valid && rsp_data.scale_error, rsp_data.noise_value == '0, "scale error with nonzero value")
	`PGN_ASSERT_NOW(a_ready_low, !req_ready, rsp_valid, "request stalled with no result pending")
	`PGN_ASSERT_NOW(a_ready_fall, $fell(req_ready), $past(rsp_valid && !rsp_ready && req_valid) || $past(rsp_valid && !rsp_ready), "request stalled without output backpressure")

endmodule

bind perlin_gradient_noise_2d pgn_chk u_pgn_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
